// ----- hdl/arp_responder_with_cache_top_macros.svh -----
// ---------------------------------------------------------------------------
// arp responder assertion macros
// shorthand for clocked assertions with reset disable
// ---------------------------------------------------------------------------
`ifndef ARP_RESPONDER_WITH_CACHE_TOP_MACROS_SVH
`define ARP_RESPONDER_WITH_CACHE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define ARPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ARPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/arpc_pkg.sv -----
// ---------------------------------------------------------------------------
// arpc_pkg
// shared types and constants of the arp responder with address cache
// ---------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    // cache geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // port widths
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 136;
    localparam int OUT_USER_W = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 48;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_LOCAL_IP = 1'b0;

    // arp header codes
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REQUEST  = 16'h0001;
    localparam logic [15:0] OP_REPLY    = 16'h0002;

    typedef enum logic [2:0] {
        ST_REPLIED   = 3'd0,
        ST_ABSORBED  = 3'd1,
        ST_BAD_HW    = 3'd2,
        ST_BAD_PROTO = 3'd3,
        ST_NOT_OURS  = 3'd4,
        ST_BAD_OP    = 3'd5,
        ST_FULL      = 3'd6,
        ST_QUERY     = 3'd7
    } status_t;

    // input payload, lowest field in the lowest bits
    typedef struct packed {
        logic [31:0] query_ip;
        logic [31:0] target_ip;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [15:0] op_code;
        logic [15:0] proto_type;
        logic [15:0] hw_type;
    } item_t;

    typedef struct packed {
        logic  kind;
        item_t pkt;
    } req_t;

    // output payload, lowest field in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [47:0] found_mac;
        logic        found;
        logic [31:0] reply_dest_ip;
        logic [47:0] reply_dest_mac;
        logic        send_reply;
    } out_data_t;

    typedef struct packed {
        status_t   status;
        out_data_t data;
    } result_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] fill;
    } ctrl_stat_t;

endpackage

`default_nettype wire

// ----- hdl/arpc_table.sv -----
// ---------------------------------------------------------------------------
// arpc_table
// address cache storage, one write port and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module arpc_table (
    input  wire logic              clk,
    input  wire arpc_pkg::mem_req_t mem_req,
    output arpc_pkg::entry_t       rd_data
);
    import arpc_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    // entries are only read below the fill count, so no reset is needed
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/arpc_ctrl.sv -----
// ---------------------------------------------------------------------------
// arpc_ctrl
// scan sequencer: walks the cache, decides the outcome, writes back
// ---------------------------------------------------------------------------
`default_nettype none

module arpc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire arpc_pkg::req_t     req,
    input  wire logic [31:0]        local_ip,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output arpc_pkg::result_t       res,
    output arpc_pkg::ctrl_stat_t    stat,
    output arpc_pkg::mem_req_t      mem_req,
    input  wire arpc_pkg::entry_t   rd_data
);
    import arpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_EVAL   = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [47:0]      hit_mac_reg, hit_mac_next;
    req_t             req_reg, req_next;
    result_t          res_reg, res_next;

    logic [31:0] key;
    logic        scan_more;
    logic        last_cmp;
    logic        ip_match;

    assign key       = req_reg.kind ? req_reg.pkt.query_ip : req_reg.pkt.sender_ip;
    assign scan_more = issue_reg < fill_reg;
    assign last_cmp  = (CNT_W'(cmp_idx_reg) + CNT_W'(1)) == fill_reg;
    assign ip_match  = rd_data.ip == key;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        issue_next     = issue_reg;
        cmp_valid_next = cmp_valid_reg;
        hit_next       = hit_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_idx_next   = hit_idx_reg;
        hit_mac_next   = hit_mac_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        mem_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next       = req;
                    issue_next     = '0;
                    cmp_valid_next = 1'b0;
                    hit_next       = 1'b0;
                    state_next     = (fill_reg == '0) ? S_EVAL : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // one read issued per cycle, each compared in the following cycle
                mem_req.rd_en   = scan_more;
                mem_req.rd_addr = issue_reg[IDX_W-1:0];
                cmp_valid_next  = scan_more;
                cmp_idx_next    = issue_reg[IDX_W-1:0];
                if (scan_more)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (cmp_valid_reg)
                begin
                    if (ip_match)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                        hit_mac_next = rd_data.mac;
                        state_next   = S_EVAL;
                    end
                    else if (last_cmp)
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                res_next   = '0;
                state_next = S_RESULT;
                if (req_reg.kind)
                begin
                    res_next.status         = ST_QUERY;
                    res_next.data.found     = hit_reg;
                    res_next.data.found_mac = hit_reg ? hit_mac_reg : '0;
                end
                else if (req_reg.pkt.hw_type != HW_ETHERNET)
                begin
                    res_next.status = ST_BAD_HW;
                end
                else if (req_reg.pkt.proto_type != PROTO_IPV4)
                begin
                    res_next.status = ST_BAD_PROTO;
                end
                else
                begin
                    mem_req.wr_data.ip  = req_reg.pkt.sender_ip;
                    mem_req.wr_data.mac = req_reg.pkt.sender_mac;
                    // refresh the known sender even on a foreign packet
                    if (hit_reg)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = hit_idx_reg;
                    end
                    if (req_reg.pkt.target_ip != local_ip)
                    begin
                        res_next.status = ST_NOT_OURS;
                    end
                    else if (!hit_reg && (fill_reg == CNT_W'(ENTRIES)))
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        if (!hit_reg)
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = fill_reg[IDX_W-1:0];
                            fill_next       = fill_reg + CNT_W'(1);
                        end
                        case (req_reg.pkt.op_code)
                            OP_REQUEST:
                            begin
                                res_next.status              = ST_REPLIED;
                                res_next.data.send_reply     = 1'b1;
                                res_next.data.reply_dest_mac = req_reg.pkt.sender_mac;
                                res_next.data.reply_dest_ip  = req_reg.pkt.sender_ip;
                            end
                            OP_REPLY:
                            begin
                                res_next.status = ST_ABSORBED;
                            end
                            default:
                            begin
                                res_next.status = ST_BAD_OP;
                            end
                        endcase
                    end
                end
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
        hit_mac_reg <= hit_mac_next;
        req_reg     <= req_next;
        res_reg     <= res_next;
    end

    assign req_ready = state_reg == S_IDLE;
    assign res_valid = state_reg == S_RESULT;
    assign res       = res_reg;
    assign stat.busy = state_reg != S_IDLE;
    assign stat.fill = fill_reg;

endmodule

`default_nettype wire

// ----- hdl/arp_responder_with_cache_top.sv -----
// ---------------------------------------------------------------------------
// arp_responder_with_cache_top
// arp responder for ipv4 over ethernet with an ip-to-mac address cache
// ---------------------------------------------------------------------------
// usage
//   slave stream: one transaction is a decoded arp packet (s_tuser = 0) or an
//   address lookup query (s_tuser = 1); each yields one result transaction
//   config port: cfg_we with cfg_addr 0 writes local_ip; index 1 (station
//   mac) is accepted and dropped, the frame builder downstream inserts it
//   scan: with an empty cache the scan is skipped, a miss reads every entry in
//   use and a hit ends the scan at the matching entry; the
//   cache is scanned one entry per cycle through the table's single read port
//   sequencing: the next transaction can be taken in the cycle after the result
//   leaves the scan engine, which takes no new one while a transaction is in flight
//   reset: cache empty, local_ip zero, both streams idle; no clearing pass
//   stall: a finished result waits in the output register while the next
//   transaction is taken and scanned; the scan engine holds its result
//   until the output register frees up
// ---------------------------------------------------------------------------
`default_nettype none

`include "arp_responder_with_cache_top_macros.svh"

module arp_responder_with_cache_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // from bit 0: hw_type, proto_type, op_code, sender_mac, sender_ip,
    // target_ip, query_ip
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [arpc_pkg::IN_DATA_W-1:0]       s_tdata,
    input  wire logic                                 s_tuser,   // kind
    // from bit 0: send_reply, reply_dest_mac, reply_dest_ip, found,
    // found_mac, zero pad
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [arpc_pkg::OUT_DATA_W-1:0]           m_tdata,
    output logic [arpc_pkg::OUT_USER_W-1:0]           m_tuser,   // status
    input  wire logic                                 cfg_we,
    input  wire logic [arpc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [arpc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import arpc_pkg::*;

    logic [31:0] local_ip_reg, local_ip_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    req_t       req;
    logic       res_valid;
    logic       res_ready;
    result_t    res;
    ctrl_stat_t stat;
    mem_req_t   mem_req;
    entry_t     rd_data;

    assign req = {s_tuser, s_tdata};

    // configuration register
    always_comb
    begin
        local_ip_next = local_ip_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_LOCAL_IP: local_ip_next = cfg_wdata[31:0];
                default:      local_ip_next = local_ip_reg;
            endcase
        end
    end

    arpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .local_ip  (local_ip_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .stat      (stat),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    arpc_table u_table (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // output register decouples the scan engine from the receiver
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            local_ip_reg  <= local_ip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.status;

    // checks
    `ARPC_ASSERT_NOW(a_fill_bound, 1'b1, stat.fill <= CNT_W'(ENTRIES), "cache fill overflow")
    `ARPC_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, stat.busy, "accepted item lost")
    `ARPC_ASSERT_NEXT(a_result_load, res_valid && res_ready, m_tvalid, "result not registered")
    `ARPC_ASSERT_NOW(a_reply_status, m_tvalid && m_tdata[0], m_tuser == ST_REPLIED, "stray reply")

endmodule

`default_nettype wire

// ----- dv/arp_responder_with_cache_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// arp_responder_with_cache_checker
// watches both streams and the register port of the arp responder, keeps its
// own copy of the address cache and compares every result transaction with
// the oldest predicted answer
// ---------------------------------------------------------------------------

module arp_responder_with_cache_checker
    import arpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [OUT_USER_W-1:0] m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  end_of_test,
    output int                    outstanding,
    output int                    fail_count
);

    // shadow of the station address and of the cache
    logic [31:0] station_ip;
    logic        tbl_valid [ENTRIES];
    logic [31:0] tbl_ip    [ENTRIES];
    logic [47:0] tbl_mac   [ENTRIES];
    int          tbl_fill;

    result_t     cache_answers [$];
    int          errs;
    int          checked;
    int          query_hits;
    int          status_seen [8];
    bit          closed;

    assign fail_count = errs;

    initial
    begin
        station_ip  = '0;
        tbl_fill    = 0;
        errs        = 0;
        checked     = 0;
        query_hits  = 0;
        closed      = 1'b0;
        foreach (tbl_valid[i])
        begin
            tbl_valid[i] = 1'b0;
            tbl_ip[i]    = '0;
            tbl_mac[i]   = '0;
        end
        foreach (status_seen[i])
            status_seen[i] = 0;
    end

    // lowest valid entry holding ip, -1 on a miss
    function automatic int lookup_entry(input logic [31:0] ip);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_valid[i] && tbl_ip[i] == ip)
                return i;
        end
        return -1;
    endfunction

    // one transaction through the responder: updates the cache, returns the answer
    function automatic result_t process_arp_item(input logic kind, input item_t it);
        result_t r;
        int      idx;
        r = '0;
        if (kind)
        begin
            r.status = ST_QUERY;
            idx = lookup_entry(it.query_ip);
            if (idx >= 0)
            begin
                r.data.found     = 1'b1;
                r.data.found_mac = tbl_mac[idx];
            end
            return r;
        end
        if (it.hw_type != HW_ETHERNET)
        begin
            r.status = ST_BAD_HW;
            return r;
        end
        if (it.proto_type != PROTO_IPV4)
        begin
            r.status = ST_BAD_PROTO;
            return r;
        end
        // refresh happens even for foreign packets and bad opcodes
        idx = lookup_entry(it.sender_ip);
        if (idx >= 0)
            tbl_mac[idx] = it.sender_mac;
        if (it.target_ip != station_ip)
        begin
            r.status = ST_NOT_OURS;
            return r;
        end
        if (idx < 0)
        begin
            if (tbl_fill >= ENTRIES)
            begin
                r.status = ST_FULL;
                return r;
            end
            tbl_valid[tbl_fill] = 1'b1;
            tbl_ip[tbl_fill]    = it.sender_ip;
            tbl_mac[tbl_fill]   = it.sender_mac;
            tbl_fill++;
        end
        if (it.op_code == OP_REQUEST)
        begin
            r.status              = ST_REPLIED;
            r.data.send_reply     = 1'b1;
            r.data.reply_dest_mac = it.sender_mac;
            r.data.reply_dest_ip  = it.sender_ip;
        end
        else if (it.op_code == OP_REPLY)
            r.status = ST_ABSORBED;
        else
            r.status = ST_BAD_OP;
        return r;
    endfunction

    // counts a failure, tells whether it is still worth a printed line
    function automatic bit count_failure();
        errs++;
        return errs <= 10;
    endfunction

    always @(posedge clk)
    begin : bus_watch
        result_t   want;
        out_data_t got;
        if (rst_n)
        begin
            if (cfg_we && cfg_addr == CFG_LOCAL_IP)
                station_ip = cfg_wdata[31:0];
            if (s_tvalid && s_tready)
                cache_answers.push_back(process_arp_item(s_tuser, item_t'(s_tdata)));
            if (m_tvalid && m_tready)
            begin
                got = out_data_t'(m_tdata);
                if (cache_answers.size() == 0)
                begin
                    if (count_failure())
                        $display("%t unexpected result: status=%0d tdata=%h",
                                 $realtime, m_tuser, m_tdata);
                end
                else
                begin
                    want = cache_answers.pop_front();
                    checked++;
                    status_seen[want.status]++;
                    if (want.data.found)
                        query_hits++;
                    if (m_tuser !== want.status
                        || got.send_reply !== want.data.send_reply
                        || got.reply_dest_mac !== want.data.reply_dest_mac
                        || got.reply_dest_ip !== want.data.reply_dest_ip
                        || got.found !== want.data.found
                        || got.found_mac !== want.data.found_mac)
                    begin
                        if (count_failure())
                        begin
                            $write("%t mismatch: want st=%0d rep=%0b dmac=%h dip=%h",
                                   $realtime, want.status, want.data.send_reply,
                                   want.data.reply_dest_mac, want.data.reply_dest_ip);
                            $write(" fnd=%0b fmac=%h | got st=%0d rep=%0b dmac=%h",
                                   want.data.found, want.data.found_mac, m_tuser,
                                   got.send_reply, got.reply_dest_mac);
                            $display(" dip=%h fnd=%0b fmac=%h",
                                     got.reply_dest_ip, got.found, got.found_mac);
                        end
                    end
                end
            end
            if (end_of_test && !closed)
            begin
                closed = 1'b1;
                if (cache_answers.size() != 0)
                begin
                    errs += cache_answers.size();
                    $display("%t %0d results never came out", $realtime,
                             cache_answers.size());
                end
                $write("checked %0d results: replied %0d, absorbed %0d, bad hw %0d,",
                       checked, status_seen[ST_REPLIED], status_seen[ST_ABSORBED],
                       status_seen[ST_BAD_HW]);
                $write(" bad proto %0d, not ours %0d, bad op %0d, full %0d,",
                       status_seen[ST_BAD_PROTO], status_seen[ST_NOT_OURS],
                       status_seen[ST_BAD_OP], status_seen[ST_FULL]);
                $display(" queries %0d (%0d hits), cache %0d/%0d",
                         status_seen[ST_QUERY], query_hits, tbl_fill, ENTRIES);
            end
        end
        outstanding <= cache_answers.size();
    end

endmodule

// ----- dv/arp_responder_with_cache_top_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// arp_responder_with_cache_top_tb
// drives arp packets and lookup queries into the responder and judges the run
// a directed opening covers header errors, refresh, insert, duplicate ips and
// odd opcodes; random traffic over a small ip pool then fills the cache and
// keeps hitting it under four idling phases and four station settings, while
// the checker beside the block predicts and compares every result
// ---------------------------------------------------------------------------

module arp_responder_with_cache_top_tb;

    import arpc_pkg::*;

    // second register index, the package only names the first
    localparam logic [CFG_ADDR_W-1:0] CFG_LOCAL_MAC = 1'b1;

    localparam int POOL_SIZE    = 20;   // more ips than cache entries, so it overflows
    localparam int PHASE_ITEMS  = 237;  // four phases, about 950 random transactions
    localparam int HOLD_CYCLES  = 200;  // long receiver hold-off
    localparam int DRAIN_CYCLES = 40;   // longer than the slowest result, a miss over a full cache

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  end_of_test;

    int                    outstanding;
    int                    fail_count;
    int                    items_sent;

    // idling knobs, percent of cycles
    int unsigned           send_idle_pct  = 0;
    int unsigned           recv_stall_pct = 0;

    // long hold-off request: the stimulus flips the toggle, the receiver counts
    logic                  hold_toggle = 1'b0;
    logic                  hold_seen   = 1'b0;
    int                    hold_left   = 0;

    // stimulus-side view of the station address, used to aim packets at us
    logic [31:0]           station_ip_now;
    logic [31:0]           ip_pool [POOL_SIZE];

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    arp_responder_with_cache_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // hw_type, proto_type, op_code, sender_mac, sender_ip,
                                 // target_ip, query_ip from bit 0
        .s_tuser   (s_tuser),    // kind
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // send_reply, reply_dest_mac, reply_dest_ip, found,
                                 // found_mac, zero pad from bit 0
        .m_tuser   (m_tuser),    // status
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    arp_responder_with_cache_checker u_arp_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .end_of_test (end_of_test),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // result side: random stalls, plus a counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // every field random, callers then overwrite what they care about
    function automatic item_t random_payload();
        item_t it;
        it.hw_type    = 16'($urandom);
        it.proto_type = 16'($urandom);
        it.op_code    = 16'($urandom);
        it.sender_mac = {16'($urandom), $urandom};
        it.sender_ip  = $urandom;
        it.target_ip  = $urandom;
        it.query_ip   = $urandom;
        return it;
    endfunction

    // one transaction on the input stream; called and returning at a rising edge
    task automatic push_transaction(input logic kind, input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= it;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic send_query(input logic [31:0] ip);
        item_t it;
        it          = random_payload();
        it.query_ip = ip;
        push_transaction(1'b1, it);
    endtask

    // well-formed ipv4 over ethernet packet
    task automatic send_pkt(input logic [15:0] op, input logic [31:0] sip,
                            input logic [47:0] smac, input logic [31:0] tip);
        item_t it;
        it            = random_payload();
        it.hw_type    = HW_ETHERNET;
        it.proto_type = PROTO_IPV4;
        it.op_code    = op;
        it.sender_ip  = sip;
        it.sender_mac = smac;
        it.target_ip  = tip;
        push_transaction(1'b0, it);
    endtask

    task automatic send_bad_header(input logic [15:0] hw, input logic [15:0] proto);
        item_t it;
        it            = random_payload();
        it.hw_type    = hw;
        it.proto_type = proto;
        push_transaction(1'b0, it);
    endtask

    // mostly well-formed packets and queries from the ip pool, some noise
    task automatic send_random_item();
        item_t       it;
        logic        kind;
        int unsigned pick;
        int unsigned opsel;
        it   = random_payload();
        kind = 1'b0;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            // noise: random header, sometimes one bit off the ethernet code
            if ($urandom_range(1) == 0)
                it.hw_type = HW_ETHERNET ^ (16'h1 << $urandom_range(15));
        end
        else if (pick < 15)
        begin
            // right hardware type, protocol random or one bit off
            it.hw_type = HW_ETHERNET;
            if ($urandom_range(1) == 0)
                it.proto_type = PROTO_IPV4 ^ (16'h1 << $urandom_range(15));
        end
        else if (pick < 60)
        begin
            it.hw_type    = HW_ETHERNET;
            it.proto_type = PROTO_IPV4;
            opsel         = $urandom_range(99);
            if (opsel < 45)
                it.op_code = OP_REQUEST;
            else if (opsel < 80)
                it.op_code = OP_REPLY;
            if ($urandom_range(9) != 0)
                it.sender_ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
            if ($urandom_range(3) != 0)
                it.target_ip = station_ip_now;
        end
        else
        begin
            kind = 1'b1;
            if ($urandom_range(4) != 0)
                it.query_ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
        end
        push_transaction(kind, it);
    endtask

    // stop offering and let every predicted result come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // both station registers, write enable held across both writes
    task automatic write_regs(input logic [31:0] ip, input logic [47:0] mac);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_LOCAL_IP;
        cfg_wdata <= {16'h0, ip};
        @(posedge clk);
        cfg_addr  <= CFG_LOCAL_MAC;
        cfg_wdata <= mac;
        @(posedge clk);
        cfg_we    <= 1'b0;
        station_ip_now = ip;
    endtask

    // run limit, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", outstanding);
        $display("** arp_responder_with_cache_top: FAILED **");
        $finish;
    end

    initial
    begin
        int unsigned send_pct_tab [4];
        int unsigned recv_pct_tab [4];
        logic [31:0] phase_ip     [4];
        logic [47:0] phase_mac    [4];
        logic [31:0] ip_a;
        logic [31:0] ip_b;
        logic [31:0] ip_c;
        logic [31:0] ip_d;
        logic [31:0] dir_ip;

        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = CFG_LOCAL_IP;
        cfg_wdata      = '0;
        end_of_test    = 1'b0;
        items_sent     = 0;
        station_ip_now = '0;

        // pool starts with the two extreme addresses
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom;
        ip_a   = ip_pool[2];
        ip_b   = ip_pool[3];
        ip_c   = ip_pool[4];
        ip_d   = $urandom;                          // outside the pool, never inserted
        dir_ip = $urandom & 32'hFFFF_FFFE;          // never all ones, so that one is foreign

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed opening ----
        // station ip still at its reset value of zero
        send_query(32'h0000_0000);                            // empty cache miss
        send_pkt(OP_REQUEST, 32'h0, 48'h0, 32'h0);            // zero ip, aimed at reset ip
        wait_idle();
        write_regs(dir_ip, {16'($urandom), $urandom});

        send_bad_header(16'h0000, PROTO_IPV4);
        send_bad_header(16'hFFFF, PROTO_IPV4);
        send_bad_header(HW_ETHERNET, 16'h0000);
        send_bad_header(HW_ETHERNET, 16'hFFFF);
        send_pkt(OP_REQUEST, ip_a, 48'hFFFF_FFFF_FFFF, dir_ip); // insert and reply
        send_query(ip_a);
        // foreign packet still refreshes the known sender
        send_pkt(OP_REQUEST, ip_a, 48'h0123_4567_89AB, 32'hFFFF_FFFF);
        send_query(ip_a);
        send_pkt(OP_REPLY, ip_b, {16'($urandom), $urandom}, dir_ip);
        // odd opcodes still insert, then refresh
        send_pkt(16'h0000, ip_c, {16'($urandom), $urandom}, dir_ip);
        send_pkt(16'hFFFF, ip_c, {16'($urandom), $urandom}, dir_ip);
        // foreign packet from an unknown sender leaves no trace
        send_pkt(OP_REQUEST, ip_d, {16'($urandom), $urandom}, ~dir_ip);
        send_query(ip_d);
        send_pkt(OP_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, dir_ip);
        send_query(32'hFFFF_FFFF);
        send_query(32'h0000_0000);
        // duplicate ip: refresh only, no second entry
        send_pkt(OP_REPLY, ip_a, {16'($urandom), $urandom}, dir_ip);
        send_query(ip_a);
        wait_idle();

        // ---- random phases ----
        // idling: none, sender, receiver, both; station settings include extremes
        send_pct_tab = '{0, 56, 0, 27};
        recv_pct_tab = '{0, 0, 56, 27};
        phase_ip     = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, ip_pool[5]};
        phase_mac    = '{48'hFFFF_FFFF_FFFF, 48'h0, {16'($urandom), $urandom},
                         {16'($urandom), $urandom}};

        for (int p = 0; p < 4; p++)
        begin
            // registers only change with the block drained
            write_regs(phase_ip[p], phase_mac[p]);
            send_idle_pct  = send_pct_tab[p];
            recv_stall_pct = recv_pct_tab[p];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-offs while the sender keeps pushing
                if ((p == 0 && n == 0) || (p == 3 && n == 100))
                    hold_toggle <= ~hold_toggle;
                send_random_item();
            end
            wait_idle();
        end

        // quiet tail, catches any stray result
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge clk);

        $display("sent %0d transactions: directed opening, then 4 idling phases with 4 station",
                 items_sent);
        $display("settings and 2 long receiver hold-offs");
        if (fail_count == 0)
            $display("** arp_responder_with_cache_top: PASSED **");
        else
            $display("** arp_responder_with_cache_top: FAILED **");
        $finish;
    end

endmodule
